// ===== rtl/core/cpd_pkg.sv =====
package cpd_pkg;

    localparam int SYMBOL_SLOTS_DEF    = 4096;
    localparam int MAX_CODE_LENGTH_DEF = 15;

    localparam int SYM_W   = 12;
    localparam int LEN_W   = 4;
    localparam int STAT_W  = 3;
    localparam int MODE_W  = 2;
    localparam int CNT_W   = 13;
    localparam int CODE_W  = 16;
    localparam int ACC_W   = 17;
    localparam int TAKEN_W = 5;
    localparam int AT_W    = 17;
    localparam int ADD_W   = 30;
    localparam int LEN_SLOTS     = 16;
    localparam int NO_MATCH_BITS = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_BUILD  = 2'd1,
        MODE_DECODE = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPTED   = 3'd0,
        ST_BUILD_OK   = 3'd1,
        ST_OVERSUB    = 3'd2,
        ST_INCOMPLETE = 3'd3,
        ST_SYMBOL     = 3'd4,
        ST_NO_MATCH   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_COUNT,
        S_DRAIN,
        S_STEP,
        S_FIN,
        S_PLACE,
        S_PDRAIN,
        S_MATCH,
        S_PUSH
    } t_state;

    typedef enum logic [2:0] {
        TBL_NONE,
        TBL_CLEAR,
        TBL_COUNT,
        TBL_STEP,
        TBL_FIN,
        TBL_PLACE,
        TBL_MATCH
    } t_tbl_op;

    typedef struct packed {
        t_tbl_op           op;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_tbl_cmd;

    typedef struct packed {
        logic            match;
        logic [AT_W-1:0] at;
        t_status         build_status;
    } t_tbl_rsp;

endpackage

// ===== rtl/core/cpd_ram.sv =====
module cpd_ram #(
    parameter int DEPTH = cpd_pkg::SYMBOL_SLOTS_DEF,
    parameter int WIDTH = cpd_pkg::SYM_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cpd_code_table.sv =====
module cpd_code_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpd_pkg::t_tbl_cmd i_cmd,
    output cpd_pkg::t_tbl_rsp o_rsp
);

    localparam int CNT_W  = cpd_pkg::CNT_W;
    localparam int CODE_W = cpd_pkg::CODE_W;
    localparam int ADD_W  = cpd_pkg::ADD_W;
    localparam int LEN_W  = cpd_pkg::LEN_W;
    localparam int NL     = cpd_pkg::LEN_SLOTS;

    logic [CNT_W-1:0]  r_count  [NL];
    logic [CODE_W-1:0] r_first  [NL];
    logic [CNT_W-1:0]  r_offset [NL];
    logic [CNT_W-1:0]  r_placed [NL];
    logic [ADD_W-1:0]  r_next;
    logic [CNT_W-1:0]  r_run;
    logic [LEN_W-1:0]  r_max_len;
    cpd_pkg::t_status  r_result;

    logic [CNT_W-1:0]  cnt_sel;
    logic [CODE_W-1:0] first_sel;
    logic [CNT_W-1:0]  off_sel;
    logic [CNT_W-1:0]  placed_sel;
    logic [ADD_W-1:0]  shifted;
    logic [CODE_W:0]   diff;
    logic [ADD_W-1:0]  add_a;
    logic [ADD_W-1:0]  add_b;
    logic [ADD_W-1:0]  add_sum;
    logic [ADD_W-1:0]  pow;
    cpd_pkg::t_status  res_over;
    cpd_pkg::t_status  res_step;
    cpd_pkg::t_status  res_fin;

    always_comb begin
        cnt_sel    = r_count[i_cmd.len];
        first_sel  = r_first[i_cmd.len];
        off_sel    = r_offset[i_cmd.len];
        placed_sel = r_placed[i_cmd.len];
        shifted    = r_next << 1;
        diff       = {1'b0, i_cmd.code} - {1'b0, first_sel};
        pow        = ADD_W'(1) << i_cmd.len;
    end

    // shared adder
    always_comb begin
        add_a = '0;
        add_b = '0;
        case (i_cmd.op)
            cpd_pkg::TBL_COUNT: begin
                add_a = ADD_W'(cnt_sel);
                add_b = ADD_W'(1);
            end
            cpd_pkg::TBL_STEP: begin
                add_a = shifted;
                add_b = ADD_W'(cnt_sel);
            end
            cpd_pkg::TBL_PLACE: begin
                add_a = ADD_W'(off_sel);
                add_b = ADD_W'(placed_sel);
            end
            cpd_pkg::TBL_MATCH: begin
                add_a = ADD_W'(off_sel);
                add_b = ADD_W'(diff[CODE_W-1:0]);
            end
            default: begin
                add_a = '0;
                add_b = '0;
            end
        endcase
        add_sum = add_a + add_b;
    end

    always_comb begin
        res_over = (add_sum > pow) ? cpd_pkg::ST_OVERSUB : r_result;
        res_step = res_over;
        if (i_cmd.len == r_max_len && res_over == cpd_pkg::ST_BUILD_OK && add_sum != pow) begin
            res_step = cpd_pkg::ST_INCOMPLETE;
        end
        res_fin = (r_max_len == '0) ? cpd_pkg::ST_INCOMPLETE : r_result;
    end

    always_comb begin
        o_rsp.match        = !diff[CODE_W] && (diff[CODE_W-1:0] < CODE_W'(cnt_sel));
        o_rsp.at           = add_sum[cpd_pkg::AT_W-1:0];
        o_rsp.build_status = r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NL; i++) begin
                r_count[i]  <= '0;
                r_first[i]  <= '0;
                r_offset[i] <= '0;
                r_placed[i] <= '0;
            end
            r_next    <= '0;
            r_run     <= '0;
            r_max_len <= '0;
            r_result  <= cpd_pkg::ST_BUILD_OK;
        end else begin
            case (i_cmd.op)
                cpd_pkg::TBL_CLEAR: begin
                    for (int i = 0; i < NL; i++) begin
                        r_count[i]  <= '0;
                        r_placed[i] <= '0;
                    end
                    r_next    <= '0;
                    r_run     <= '0;
                    r_max_len <= '0;
                    r_result  <= cpd_pkg::ST_BUILD_OK;
                end
                cpd_pkg::TBL_COUNT: begin
                    if (i_cmd.len != '0) begin
                        r_count[i_cmd.len] <= add_sum[CNT_W-1:0];
                        if (i_cmd.len > r_max_len) begin
                            r_max_len <= i_cmd.len;
                        end
                    end
                end
                cpd_pkg::TBL_STEP: begin
                    r_first[i_cmd.len]  <= shifted[CODE_W-1:0];
                    r_offset[i_cmd.len] <= r_run;
                    r_run               <= r_run + cnt_sel;
                    r_next              <= add_sum;
                    r_result            <= res_step;
                end
                cpd_pkg::TBL_FIN: begin
                    r_result <= res_fin;
                    if (res_fin != cpd_pkg::ST_BUILD_OK) begin
                        for (int i = 0; i < NL; i++) begin
                            r_count[i] <= '0;
                        end
                    end
                end
                cpd_pkg::TBL_PLACE: begin
                    r_placed[i_cmd.len] <= placed_sel + CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/canonical_prefix_code_decoder.sv =====
// Canonical prefix-code decoder. Every request gives exactly one result. A load request
// (mode 0) or an unknown mode goes straight to the output register; a decode bit (mode 2)
// first compares the accumulated code against the per-length tables and reads the sorted
// symbol memory, then registers the result. A build request (mode 1) makes two sweeps over
// the length memory (one to count lengths, one to place symbols and clear the store) and
// one table step per code length through the shared adder. After reset the length memory
// is cleared before the first request is taken. The block holds o_stall high while a
// request is in progress; a finished result waits in the output register while the next
// request is taken.
module canonical_prefix_code_decoder #(
    parameter int SYMBOL_SLOTS    = cpd_pkg::SYMBOL_SLOTS_DEF,
    parameter int MAX_CODE_LENGTH = cpd_pkg::MAX_CODE_LENGTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [cpd_pkg::MODE_W-1:0]  i_mode,
    input  logic [cpd_pkg::SYM_W-1:0]   i_symbol_value,
    input  logic [cpd_pkg::LEN_W-1:0]   i_code_length,
    input  logic                        i_stream_bit,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [cpd_pkg::STAT_W-1:0]  o_status,
    output logic [cpd_pkg::SYM_W-1:0]   o_symbol
);

    localparam int AW      = $clog2(SYMBOL_SLOTS);
    localparam int SYM_W   = cpd_pkg::SYM_W;
    localparam int LEN_W   = cpd_pkg::LEN_W;
    localparam int ACC_W   = cpd_pkg::ACC_W;
    localparam int TAKEN_W = cpd_pkg::TAKEN_W;
    localparam int CODE_W  = cpd_pkg::CODE_W;
    localparam int AT_W    = cpd_pkg::AT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(SYMBOL_SLOTS - 1);

    cpd_pkg::t_state   r_state;
    cpd_pkg::t_state   n_state;
    logic [AW-1:0]     r_addr;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_sym;
    logic [LEN_W-1:0]  r_step_len;
    logic [ACC_W-1:0]  r_acc;
    logic [TAKEN_W-1:0] r_taken;
    cpd_pkg::t_status  r_pend_status;
    logic              r_sym_sel;
    logic              r_out_vld;
    cpd_pkg::t_status  r_out_status;
    logic [SYM_W-1:0]  r_out_symbol;

    logic              acc_in;
    logic              out_free;
    logic              last_addr;
    logic              load_ok;
    logic              match_en;
    logic              hit;
    logic              at_ok;
    logic              place_en;
    logic [CODE_W-1:0] code_mask;

    logic              len_we;
    logic [AW-1:0]     len_waddr;
    logic [LEN_W-1:0]  len_wdata;
    logic              len_re;
    logic [LEN_W-1:0]  len_rdata;
    logic              sym_we;
    logic              sym_re;
    logic [SYM_W-1:0]  sym_rdata;

    cpd_pkg::t_tbl_cmd tbl_cmd;
    cpd_pkg::t_tbl_rsp tbl_rsp;

    assign acc_in    = i_valid && !o_stall;
    assign out_free  = !r_out_vld || !i_stall;
    assign last_addr = (r_addr == LAST_ADDR);
    assign load_ok   = ({1'b0, i_symbol_value} < (SYM_W + 1)'(SYMBOL_SLOTS))
                       && (i_code_length <= LEN_W'(MAX_CODE_LENGTH));
    assign match_en  = (r_taken != '0) && (r_taken <= TAKEN_W'(MAX_CODE_LENGTH));
    assign code_mask = (CODE_W'(1) << r_taken[LEN_W-1:0]) - CODE_W'(1);
    assign at_ok     = tbl_rsp.at < AT_W'(SYMBOL_SLOTS);
    assign hit       = match_en && tbl_rsp.match;
    assign place_en  = (r_state == cpd_pkg::S_PLACE || r_state == cpd_pkg::S_PDRAIN)
                       && r_rd_vld && (tbl_rsp.build_status == cpd_pkg::ST_BUILD_OK)
                       && (len_rdata != '0);

    cpd_ram #(
        .DEPTH (SYMBOL_SLOTS),
        .WIDTH (LEN_W)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (len_re),
        .i_raddr (r_addr),
        .o_rdata (len_rdata)
    );

    cpd_ram #(
        .DEPTH (SYMBOL_SLOTS),
        .WIDTH (SYM_W)
    ) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (tbl_rsp.at[AW-1:0]),
        .i_wdata (SYM_W'(r_rd_sym)),
        .i_re    (sym_re),
        .i_raddr (tbl_rsp.at[AW-1:0]),
        .o_rdata (sym_rdata)
    );

    cpd_code_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_rsp   (tbl_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cpd_pkg::S_INIT: begin
                if (last_addr) n_state = cpd_pkg::S_IDLE;
            end
            cpd_pkg::S_IDLE: begin
                if (acc_in) begin
                    unique case (i_mode)
                        cpd_pkg::MODE_BUILD:  n_state = cpd_pkg::S_COUNT;
                        cpd_pkg::MODE_DECODE: n_state = cpd_pkg::S_MATCH;
                        default:              n_state = cpd_pkg::S_PUSH;
                    endcase
                end
            end
            cpd_pkg::S_COUNT: begin
                if (last_addr) n_state = cpd_pkg::S_DRAIN;
            end
            cpd_pkg::S_DRAIN: n_state = cpd_pkg::S_STEP;
            cpd_pkg::S_STEP: begin
                if (r_step_len == LEN_W'(MAX_CODE_LENGTH)) n_state = cpd_pkg::S_FIN;
            end
            cpd_pkg::S_FIN: n_state = cpd_pkg::S_PLACE;
            cpd_pkg::S_PLACE: begin
                if (last_addr) n_state = cpd_pkg::S_PDRAIN;
            end
            cpd_pkg::S_PDRAIN: n_state = cpd_pkg::S_PUSH;
            cpd_pkg::S_MATCH:  n_state = cpd_pkg::S_PUSH;
            cpd_pkg::S_PUSH: begin
                if (out_free) n_state = cpd_pkg::S_IDLE;
            end
            default: n_state = cpd_pkg::S_IDLE;
        endcase
    end

    // memory and table controls
    always_comb begin
        o_stall   = (r_state != cpd_pkg::S_IDLE);
        len_we    = 1'b0;
        len_waddr = r_addr;
        len_wdata = '0;
        len_re    = 1'b0;
        sym_we    = 1'b0;
        sym_re    = 1'b0;
        tbl_cmd   = '{op: cpd_pkg::TBL_NONE, len: '0, code: '0};
        unique case (r_state)
            cpd_pkg::S_INIT: begin
                len_we = 1'b1;
            end
            cpd_pkg::S_IDLE: begin
                if (acc_in && i_mode == cpd_pkg::MODE_LOAD && load_ok) begin
                    len_we    = 1'b1;
                    len_waddr = i_symbol_value[AW-1:0];
                    len_wdata = i_code_length;
                end
                if (acc_in && i_mode == cpd_pkg::MODE_BUILD) begin
                    tbl_cmd.op = cpd_pkg::TBL_CLEAR;
                end
            end
            cpd_pkg::S_COUNT, cpd_pkg::S_DRAIN: begin
                len_re = (r_state == cpd_pkg::S_COUNT);
                if (r_rd_vld) begin
                    tbl_cmd.op  = cpd_pkg::TBL_COUNT;
                    tbl_cmd.len = len_rdata;
                end
            end
            cpd_pkg::S_STEP: begin
                tbl_cmd.op  = cpd_pkg::TBL_STEP;
                tbl_cmd.len = r_step_len;
            end
            cpd_pkg::S_FIN: begin
                tbl_cmd.op = cpd_pkg::TBL_FIN;
            end
            cpd_pkg::S_PLACE, cpd_pkg::S_PDRAIN: begin
                // second sweep clears the length store as it reads it
                len_re = (r_state == cpd_pkg::S_PLACE);
                len_we = (r_state == cpd_pkg::S_PLACE);
                if (place_en) begin
                    tbl_cmd.op  = cpd_pkg::TBL_PLACE;
                    tbl_cmd.len = len_rdata;
                    sym_we      = at_ok;
                end
            end
            cpd_pkg::S_MATCH: begin
                if (match_en) begin
                    tbl_cmd.op   = cpd_pkg::TBL_MATCH;
                    tbl_cmd.len  = r_taken[LEN_W-1:0];
                    tbl_cmd.code = r_acc[CODE_W-1:0] & code_mask;
                    sym_re       = tbl_rsp.match && at_ok;
                end
            end
            cpd_pkg::S_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cpd_pkg::S_INIT;
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_step_len <= '0;
            r_acc      <= ACC_W'(1);
            r_taken    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= len_re;
            if (r_state == cpd_pkg::S_INIT || r_state == cpd_pkg::S_COUNT
                    || r_state == cpd_pkg::S_PLACE) begin
                r_addr <= last_addr ? '0 : r_addr + AW'(1);
            end
            if (r_state == cpd_pkg::S_DRAIN) begin
                r_step_len <= LEN_W'(1);
            end else if (r_state == cpd_pkg::S_STEP) begin
                r_step_len <= r_step_len + LEN_W'(1);
            end
            if (acc_in && i_mode == cpd_pkg::MODE_DECODE) begin
                r_acc   <= {r_acc[ACC_W-2:0], i_stream_bit};
                r_taken <= r_taken + TAKEN_W'(1);
            end else if (acc_in && i_mode == cpd_pkg::MODE_BUILD) begin
                r_acc   <= ACC_W'(1);
                r_taken <= '0;
            end else if (r_state == cpd_pkg::S_MATCH
                    && (hit || r_taken >= TAKEN_W'(cpd_pkg::NO_MATCH_BITS))) begin
                r_acc   <= ACC_W'(1);
                r_taken <= '0;
            end
            if (r_state == cpd_pkg::S_PUSH && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // pending result and output register
    always_ff @(posedge i_clk) begin
        r_rd_sym <= r_addr;
        if (acc_in) begin
            r_pend_status <= cpd_pkg::ST_ACCEPTED;
            r_sym_sel     <= 1'b0;
        end else if (r_state == cpd_pkg::S_PDRAIN) begin
            r_pend_status <= tbl_rsp.build_status;
            r_sym_sel     <= 1'b0;
        end else if (r_state == cpd_pkg::S_MATCH) begin
            r_sym_sel <= hit && at_ok;
            if (hit) begin
                r_pend_status <= cpd_pkg::ST_SYMBOL;
            end else if (r_taken >= TAKEN_W'(cpd_pkg::NO_MATCH_BITS)) begin
                r_pend_status <= cpd_pkg::ST_NO_MATCH;
            end else begin
                r_pend_status <= cpd_pkg::ST_ACCEPTED;
            end
        end
        if (r_state == cpd_pkg::S_PUSH && out_free) begin
            r_out_status <= r_pend_status;
            r_out_symbol <= r_sym_sel ? sym_rdata : '0;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_status = r_out_status;
    assign o_symbol = r_out_symbol;

    a_marker : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc >> r_taken) == ACC_W'(1))
        else $error("accumulator marker bit out of place");

    a_taken : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= TAKEN_W'(cpd_pkg::NO_MATCH_BITS))
        else $error("bit count past no-match limit");

    a_sym_sel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpd_pkg::S_PUSH && r_sym_sel) |-> r_pend_status == cpd_pkg::ST_SYMBOL)
        else $error("symbol data selected without symbol status");

    a_no_place_fail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sym_we |-> tbl_rsp.build_status == cpd_pkg::ST_BUILD_OK)
        else $error("sorted store written after failed build");

endmodule
